// ===== rtl/bpa_pkg.sv =====
// shared types, constants and helpers for the bitmap page allocator
package bpa_pkg;

  // bitmap row geometry: one memory row holds 64 page bits
  localparam int unsigned ROW_W   = 64;
  localparam int unsigned ROW_SEL = 6;

  // result and count widths
  localparam int unsigned ADDR_W = 28;
  localparam int unsigned CNT_W  = 17;

  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [CNT_W-1:0] PAGES_RESET    = 17'h10000;
  localparam logic [ROW_W-1:0] ROW_FULL       = '1;

  // operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // register index carried by paddr[2]
  localparam logic CFG_IDX_PAGES_IN_USE = 1'b0;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  // position of the lowest zero bit of a row (row must not be all ones)
  function automatic logic [ROW_SEL-1:0] lowest_zero(input logic [ROW_W-1:0] row);
    logic [ROW_W-1:0]   oh;
    logic [ROW_SEL-1:0] idx;
    oh  = ~row & (row + ROW_W'(1));
    idx = '0;
    for (int j = 0; j < ROW_W; j++) begin
      if (oh[j]) begin
        idx = idx | ROW_SEL'(j);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bitmap_page_allocator_core.sv =====
// first-fit bitmap page allocator: sequencer, bitmap memory and config register
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | to core   | in_valid_i / in_stall_o   | func_i, page_address_i
//  out     | from core | out_valid_o / out_stall_i | alloc_address_o, out_of_memory_o,
//          |           |                           | free_count_o, used_count_o
//  cfg     | to core   | psel/penable/pwrite       | paddr, pwdata, prdata, pready
//
// an allocate word scans up to ceil(limit/64) 64-page rows, each by a read, then a
// find-first-zero check, between accept and result
// a free word steps through accept, read, modify-write and result; an unmanaged one
// skips read and modify-write; after reset a fill pass marks every page used, one row
// a cycle, with no word accepted meanwhile; config writes are taken at any time
// a word is accepted only in idle; a full, stalled output register holds the result step
module bitmap_page_allocator_core #(
  parameter int unsigned MAX_PAGES  = 65536,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [31:0]                   page_address_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpa_pkg::ADDR_W-1:0]    alloc_address_o,
  output logic                          out_of_memory_o,
  output logic [bpa_pkg::CNT_W-1:0]     free_count_o,
  output logic [bpa_pkg::CNT_W-1:0]     used_count_o,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // geometry derived from the parameters
  localparam int unsigned ROWS = (MAX_PAGES + bpa_pkg::ROW_W - 1) / bpa_pkg::ROW_W;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PS   = $clog2(PAGE_BYTES);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  // sequencer and control
  bpa_pkg::state_e state_q, state_d;
  logic [RW-1:0]  init_q, init_d;
  logic [RW-1:0]  row_q, row_d;
  logic [5:0]     bit_q, bit_d;
  logic           func_q, func_d;

  // config and counters
  logic [bpa_pkg::CNT_W-1:0] pages_q;
  logic [bpa_pkg::CNT_W-1:0] free_q, free_d;

  // result staging
  logic [bpa_pkg::ADDR_W-1:0] res_addr_q, res_addr_d;
  logic                       res_oom_q, res_oom_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic [bpa_pkg::ADDR_W-1:0] out_addr_q;
  logic                       out_oom_q;
  logic [bpa_pkg::CNT_W-1:0]  out_free_q;
  logic [bpa_pkg::CNT_W-1:0]  out_used_q;
  logic                       out_load;

  // bitmap memory, one bit per page, 1 = used
  logic [bpa_pkg::ROW_W-1:0] mem_q [ROWS];
  logic [bpa_pkg::ROW_W-1:0] rdata_q;
  logic                      mem_re;
  logic                      mem_we;
  logic [RW-1:0]             mem_waddr;
  logic [bpa_pkg::ROW_W-1:0] mem_wdata;

  // datapath helpers
  logic                      in_acc;
  logic                      cfg_wr;
  logic [bpa_pkg::CNT_W-1:0] limit;
  logic [11:0]               num_rows;
  logic [31:0]               req_page;
  logic                      req_in_range;
  logic                      row_is_last;
  logic [bpa_pkg::ROW_W-1:0] tail_mask;
  logic [bpa_pkg::ROW_W-1:0] eff_row;
  logic                      row_has_free;
  logic [5:0]                zero_idx;
  logic [RW:0]               row_next;
  logic                      page_used;
  logic [RW+6+PS-1:0]        byte_addr_full;

  // -------------------------------------------------------------------------
  // config port: one register, pages_in_use, at byte address 0
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == bpa_pkg::CFG_IDX_PAGES_IN_USE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == bpa_pkg::CFG_IDX_PAGES_IN_USE) begin
      prdata = 32'(pages_q);
    end
  end

  // managed limit is min(pages_in_use, MAX_PAGES); it always fits the register width
  assign limit = ({15'd0, pages_q} < 32'(MAX_PAGES)) ? pages_q
                                                      : bpa_pkg::CNT_W'(MAX_PAGES);
  // rows holding at least one managed page
  assign num_rows = {1'b0, limit[16:6]} + 12'(limit[5:0] != 6'd0);

  // free request: byte address to page number, range check against the limit
  assign req_page     = page_address_i >> PS;
  assign req_in_range = req_page < 32'(limit);

  // unmanaged tail of the last partial row reads as used
  assign row_is_last  = (17'(row_q) == 17'(limit[16:6]));
  assign tail_mask    = row_is_last ? ~((64'd1 << limit[5:0]) - 64'd1) : '0;
  assign eff_row      = rdata_q | tail_mask;
  assign row_has_free = (eff_row != bpa_pkg::ROW_FULL);
  assign zero_idx     = bpa_pkg::lowest_zero(eff_row);
  assign row_next     = {1'b0, row_q} + (RW+1)'(1);
  assign page_used    = rdata_q[bit_q];

  // page number times page size, masked to the address width
  assign byte_addr_full = {row_q, zero_idx, {PS{1'b0}}};

  assign in_stall_o = (state_q != bpa_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == bpa_pkg::ST_RESULT) && (!out_valid_q || !out_stall_i);

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    row_d       = row_q;
    bit_d       = bit_q;
    func_d      = func_q;
    free_d      = free_q;
    res_addr_d  = res_addr_q;
    res_oom_d   = res_oom_q;
    out_valid_d = out_valid_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = row_q;
    mem_wdata   = rdata_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bpa_pkg::ST_INIT: begin
        // fill pass: every page starts out used
        mem_we    = 1'b1;
        mem_waddr = init_q;
        mem_wdata = bpa_pkg::ROW_FULL;
        init_d    = init_q + RW'(1);
        if (init_q == LAST_ROW) begin
          state_d = bpa_pkg::ST_IDLE;
        end
      end

      bpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          func_d     = func_i;
          res_addr_d = '0;
          res_oom_d  = 1'b0;
          if (func_i == bpa_pkg::FUNC_ALLOC) begin
            row_d = '0;
            if (num_rows == 12'd0) begin
              res_oom_d = 1'b1;
              state_d   = bpa_pkg::ST_RESULT;
            end else begin
              state_d = bpa_pkg::ST_READ;
            end
          end else begin
            row_d = RW'(req_page >> bpa_pkg::ROW_SEL);
            bit_d = req_page[5:0];
            // out-of-range free changes nothing
            state_d = req_in_range ? bpa_pkg::ST_READ : bpa_pkg::ST_RESULT;
          end
        end
      end

      bpa_pkg::ST_READ: begin
        mem_re  = 1'b1;
        state_d = bpa_pkg::ST_CHECK;
      end

      bpa_pkg::ST_CHECK: begin
        if (func_q == bpa_pkg::FUNC_ALLOC) begin
          if (row_has_free) begin
            mem_we     = 1'b1;
            mem_wdata  = rdata_q | (64'd1 << zero_idx);
            res_addr_d = bpa_pkg::ADDR_W'(byte_addr_full);
            if (free_q != '0) begin
              free_d = free_q - bpa_pkg::CNT_W'(1);
            end
            state_d = bpa_pkg::ST_RESULT;
          end else if (17'(row_next) < 17'(num_rows)) begin
            row_d   = RW'(row_next);
            state_d = bpa_pkg::ST_READ;
          end else begin
            res_oom_d = 1'b1;
            state_d   = bpa_pkg::ST_RESULT;
          end
        end else begin
          if (page_used) begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q & ~(64'd1 << bit_q);
            if (free_q != bpa_pkg::CNT_MAX) begin
              free_d = free_q + bpa_pkg::CNT_W'(1);
            end
          end
          state_d = bpa_pkg::ST_RESULT;
        end
      end

      bpa_pkg::ST_RESULT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = bpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::ST_INIT;
      init_q      <= '0;
      free_q      <= '0;
      pages_q     <= bpa_pkg::PAGES_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        pages_q <= pwdata[bpa_pkg::CNT_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    bit_q      <= bit_d;
    func_q     <= func_d;
    res_addr_q <= res_addr_d;
    res_oom_q  <= res_oom_d;
    if (out_load) begin
      out_addr_q <= res_addr_q;
      out_oom_q  <= res_oom_q;
      out_free_q <= free_q;
      out_used_q <= (pages_q > free_q) ? (pages_q - free_q) : '0;
    end
  end

  // bitmap memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[row_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign alloc_address_o = out_addr_q;
  assign out_of_memory_o = out_oom_q;
  assign free_count_o    = out_free_q;
  assign used_count_o    = out_used_q;

endmodule

// ===== rtl/bpa_chk.sv =====
// port-level checker for the bitmap page allocator and its bind
module bpa_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [bpa_pkg::ADDR_W-1:0] alloc_address_o,
  input logic                       out_of_memory_o,
  input logic                       pready
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // one word at a time: after an accepted word the request side stalls
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while busy");

  // out of memory never carries an address
  a_oom_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_memory_o |-> alloc_address_o == '0)
    else $error("address reported with out of memory");

  // config port is never wait-stated
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind bitmap_page_allocator_core bpa_chk u_bpa_chk (.*);
